@@ design/sfsr_pkg.sv @@
// Package with the types, widths and codes of the scale frame stable reading block.
`default_nettype none
package sfsr_pkg;

  // Field widths.
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int SUM_W    = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0]            status_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_HEADER_BYTE     = 2'd0;
  localparam cfg_idx_t CFG_STABLE_REPEATS  = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT_SECONDS = 2'd2;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0]  HEADER_RESET  = 8'h54;
  localparam logic [COUNT_W-1:0] REPEATS_RESET = 8'd10;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd15;

  // Result status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_LEN  = 2'd1;
  localparam status_t ST_BAD_HDR  = 2'd2;
  localparam status_t ST_BAD_CHK  = 2'd3;

  // Frame length that a valid frame has.
  localparam logic [LEN_W-1:0]   FRAME_LEN = 4'd5;
  // Count at which the repeat counter saturates.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // One input transaction.
  typedef struct packed {
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [TIME_W-1:0] now_seconds;
  } in_item_t;

endpackage
`default_nettype wire

@@ design/sfsr_in_if.sv @@
// Interface of the input frame channel.
`default_nettype none
interface sfsr_in_if;
  import sfsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] byte0;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [BYTE_W-1:0] byte3;
  logic [BYTE_W-1:0] byte4;
  logic [TIME_W-1:0] now_seconds;

  modport source (
    output valid, frame_length, byte0, byte1, byte2, byte3, byte4, now_seconds,
    input  ready
  );

  modport sink (
    input  valid, frame_length, byte0, byte1, byte2, byte3, byte4, now_seconds,
    output ready
  );

endinterface
`default_nettype wire

@@ design/sfsr_out_if.sv @@
// Interface of the result channel.
`default_nettype none
interface sfsr_out_if;
  import sfsr_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [WEIGHT_W-1:0] weight_tenths;
  logic [COUNT_W-1:0]  repeat_count;
  logic                stable_push;

  modport source (
    output valid, status, weight_tenths, repeat_count, stable_push,
    input  ready
  );

  modport sink (
    input  valid, status, weight_tenths, repeat_count, stable_push,
    output ready
  );

endinterface
`default_nettype wire

@@ design/scale_frame_stable_reading.sv @@
// Top level: frame check, checksum, timeout and stable weight detection.
// Throughput: one frame per cycle while the result side takes results; an input register and a
// result register form the pipeline. The input side keeps taking frames while a result waits,
// until both registers are full.
// Reset (synchronous, rst_n low) empties the pipeline, clears the weight history and
// restores the configuration registers to header 0x54, 10 repeats and 15 seconds.
`default_nettype none
module scale_frame_stable_reading (
  input  wire                     clk,
  input  wire                     rst_n,
  sfsr_in_if.sink                 in_ch,
  sfsr_out_if.source              out_ch,
  input  wire                     cfg_we,
  input  wire sfsr_pkg::cfg_idx_t  cfg_index,
  input  wire sfsr_pkg::cfg_data_t cfg_wdata
);
  import sfsr_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0]  header_byte_r;
  logic [COUNT_W-1:0] stable_repeats_r;
  logic [TMO_W-1:0]   timeout_seconds_r;

  // History state.
  logic [WEIGHT_W-1:0] last_weight_r, last_weight_nxt;
  logic                last_valid_r, last_valid_nxt;
  logic [COUNT_W-1:0]  same_count_r, same_count_nxt;
  logic [TIME_W-1:0]   last_seen_r, last_seen_nxt;

  // Pipeline registers.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  status_t             out_status_r, out_status_nxt;
  logic [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_push_r, out_push_nxt;

  logic advance;
  logic in_fire;
  logic commit;

  // Decode signals.
  logic [BYTE_W-1:0]   b0, b1, b2, b3, chk;
  logic [SUM_W-1:0]    sum;
  logic                add_two;
  logic [BYTE_W:0]     chk_calc;
  logic                frame_ok;
  logic [WEIGHT_W-1:0] weight;
  logic [TIME_W-1:0]   diff;
  logic                late;
  logic                base_valid;
  logic [COUNT_W-1:0]  base_count;
  logic [COUNT_W-1:0]  count_inc;
  logic                same_weight;

  // Handshake: the result register moves when empty or taken.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r     <= HEADER_RESET;
      stable_repeats_r  <= REPEATS_RESET;
      timeout_seconds_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_BYTE:     header_byte_r     <= cfg_wdata[BYTE_W-1:0];
        CFG_STABLE_REPEATS:  stable_repeats_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_TIMEOUT_SECONDS: timeout_seconds_r <= cfg_wdata[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.frame_length <= in_ch.frame_length;
      s1_item_r.byte0        <= in_ch.byte0;
      s1_item_r.byte1        <= in_ch.byte1;
      s1_item_r.byte2        <= in_ch.byte2;
      s1_item_r.byte3        <= in_ch.byte3;
      s1_item_r.byte4        <= in_ch.byte4;
      s1_item_r.now_seconds  <= in_ch.now_seconds;
    end
  end

  // Checksum over the inverted bytes: low byte forced odd, plus two when the sum is 256 or more above the forced byte.
  assign b0  = ~s1_item_r.byte0;
  assign b1  = ~s1_item_r.byte1;
  assign b2  = ~s1_item_r.byte2;
  assign b3  = ~s1_item_r.byte3;
  assign chk = ~s1_item_r.byte4;
  assign sum = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
  assign add_two  = sum[9] || (sum[8] && sum[0]);
  assign chk_calc = {1'b0, sum[7:1], 1'b1} + (add_two ? 9'd2 : 9'd0);
  assign weight   = {b2, b3};

  // Frame checks in priority order.
  always_comb begin
    if (s1_item_r.frame_length != FRAME_LEN) begin
      out_status_nxt = ST_BAD_LEN;
    end else if (s1_item_r.byte0 != header_byte_r) begin
      out_status_nxt = ST_BAD_HDR;
    end else if (chk_calc != {1'b0, chk}) begin
      out_status_nxt = ST_BAD_CHK;
    end else begin
      out_status_nxt = ST_OK;
    end
  end
  assign frame_ok = (out_status_nxt == ST_OK);

  // Timeout on a signed wrapping difference.
  assign diff = s1_item_r.now_seconds - last_seen_r;
  assign late = !diff[TIME_W-1] && (diff > {16'd0, timeout_seconds_r});
  assign base_valid  = late ? 1'b0 : last_valid_r;
  assign base_count  = late ? '0 : same_count_r;
  assign same_weight = base_valid && (last_weight_r == weight);
  assign count_inc   = base_count + 8'd1;

  // History update and result fields for an accepted frame.
  always_comb begin
    last_weight_nxt = last_weight_r;
    last_valid_nxt  = base_valid;
    same_count_nxt  = base_count;
    last_seen_nxt   = s1_item_r.now_seconds;
    out_push_nxt    = 1'b0;
    if (same_weight) begin
      if (base_count != COUNT_MAX) begin
        same_count_nxt = count_inc;
        out_push_nxt   = (count_inc == stable_repeats_r) && (weight != '0);
      end
    end else begin
      same_count_nxt  = '0;
      last_weight_nxt = weight;
      last_valid_nxt  = 1'b1;
    end
  end

  assign out_weight_nxt = frame_ok ? weight : '0;
  assign out_count_nxt  = frame_ok ? same_count_nxt : same_count_r;
  assign commit         = s1_valid_r && advance && frame_ok;

  // History registers change only on an accepted frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_weight_r <= '0;
      last_valid_r  <= 1'b0;
      same_count_r  <= '0;
      last_seen_r   <= '0;
    end else if (commit) begin
      last_weight_r <= last_weight_nxt;
      last_valid_r  <= last_valid_nxt;
      same_count_r  <= same_count_nxt;
      last_seen_r   <= last_seen_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_status_r <= out_status_nxt;
      out_weight_r <= out_weight_nxt;
      out_count_r  <= out_count_nxt;
      out_push_r   <= frame_ok && out_push_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.weight_tenths = out_weight_r;
  assign out_ch.repeat_count  = out_count_r;
  assign out_ch.stable_push   = out_push_r;

`ifndef SYNTHESIS
  // A push only comes with an accepted frame.
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_push_r |-> out_status_r == ST_OK)
    else $error("push flagged on a rejected frame");

  // A rejected frame reports no weight.
  a_reject_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_weight_r == '0)
    else $error("rejected frame carries a weight");

  // A push reports the configured repeat count and a nonzero weight.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_push_r |-> out_count_r == stable_repeats_r && out_weight_r != '0)
    else $error("push with wrong count or zero weight");

  // Without a previous reading the repeat count is zero.
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !last_valid_r |-> same_count_r == '0)
    else $error("repeat count set without a previous reading");

  // The history holds when no accepted frame passes.
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(last_weight_r) && $stable(same_count_r) && $stable(last_seen_r))
    else $error("history changed without an accepted frame");
`endif

endmodule
`default_nettype wire

@@ bench/scale_frame_stable_reading_tb.sv @@
// Testbench for the scale frame stable reading block: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module scale_frame_stable_reading_tb;
  import sfsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  // One expected or observed result transaction.
  typedef struct packed {
    status_t             status;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;
    logic                push;
  } reading_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  sfsr_in_if  in_if ();
  sfsr_out_if out_if ();

  scale_frame_stable_reading u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Configuration as the block should hold it.
  logic [BYTE_W-1:0]   cur_header;
  logic [COUNT_W-1:0]  cur_repeats;
  logic [TMO_W-1:0]    cur_timeout;

  // Weight history as the block should hold it.
  logic [WEIGHT_W-1:0] hist_weight;
  logic                hist_known;
  logic [COUNT_W-1:0]  hist_count;
  logic [TIME_W-1:0]   hist_time;

  reading_t            expected_readings[$];
  int unsigned         frames_sent;
  int unsigned         readings_seen;
  int unsigned         fail_count;
  logic [TIME_W-1:0]   sim_seconds;
  bit                  send_idle_en;
  bit                  sink_idle_en;
  int unsigned         sink_hold_len;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Checksum over the inverted bytes 0..3; values above 255 can never match.
  function automatic logic [9:0] frame_checksum(input logic [7:0] i0, input logic [7:0] i1,
                                                input logic [7:0] i2, input logic [7:0] i3);
    logic [9:0] total;
    logic [9:0] folded;
    total  = i0 + i1 + i2 + i3;
    folded = {2'b00, total[7:0] | 8'h01};
    if (total >= folded && total - folded >= 10'd256) folded = folded + 10'd2;
    return folded;
  endfunction

  // Works out the result of one frame and advances the weight history.
  function automatic reading_t predict_reading(input in_item_t f);
    reading_t          r;
    logic [9:0]        sum_chk;
    logic [TIME_W-1:0] elapsed;
    r.status = ST_OK;
    r.weight = '0;
    r.push   = 1'b0;
    if (f.frame_length != FRAME_LEN) begin
      r.status = ST_BAD_LEN;
    end else if (f.byte0 != cur_header) begin
      r.status = ST_BAD_HDR;
    end else begin
      sum_chk = frame_checksum(~f.byte0, ~f.byte1, ~f.byte2, ~f.byte3);
      if (sum_chk != {2'b00, ~f.byte4}) begin
        r.status = ST_BAD_CHK;
      end else begin
        r.weight = {~f.byte2, ~f.byte3};
        // A negative time difference never counts as a timeout.
        elapsed = f.now_seconds - hist_time;
        if (!elapsed[31] && elapsed > {16'h0000, cur_timeout}) begin
          hist_known = 1'b0;
          hist_count = '0;
        end
        hist_time = f.now_seconds;
        if (hist_known && hist_weight == r.weight) begin
          if (hist_count != COUNT_MAX) begin
            hist_count = hist_count + 8'd1;
            if (hist_count == cur_repeats && r.weight != '0) r.push = 1'b1;
          end
        end else begin
          hist_count  = '0;
          hist_weight = r.weight;
          hist_known  = 1'b1;
        end
      end
    end
    r.count = hist_count;
    return r;
  endfunction

  // Well-formed frame for the current header; overflow picks a checksum above 255.
  function automatic in_item_t build_frame(input logic [15:0] w, input logic [31:0] stamp,
                                           input bit overflow);
    in_item_t   f;
    logic [9:0] sum_chk;
    f.frame_length = FRAME_LEN;
    f.byte0        = cur_header;
    f.byte2        = ~w[15:8];
    f.byte3        = ~w[7:0];
    f.now_seconds  = stamp;
    do begin
      f.byte1 = 8'($urandom_range(0, 255));
      sum_chk = frame_checksum(~f.byte0, ~f.byte1, ~f.byte2, ~f.byte3);
    end while ((sum_chk > 10'd255) != overflow);
    f.byte4 = ~sum_chk[7:0];
    return f;
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h0000;
    if (r < 25) return 16'hFFFF;
    if (r < 35) return 16'h0001;
    if (r < 60) return 16'($urandom_range(1, 1000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Time step between frames, with timeout edges, backward steps and wild jumps.
  function automatic logic [31:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 78) return {16'h0000, cur_timeout};
    if (r < 86) return {16'h0000, cur_timeout} + 32'd1;
    if (r < 92) return 32'd0 - $urandom_range(1, 100);
    if (r < 96) return $urandom;
    return $urandom_range(3, 40);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Broken frame: random fields, wrong length, wrong header or corrupt checksum.
  function automatic in_item_t build_noise();
    in_item_t f;
    f = build_frame(pick_weight(), sim_seconds, 1'b0);
    case ($urandom_range(0, 3))
      0: begin
        f.frame_length = 4'($urandom_range(0, 15));
        f.byte0        = 8'($urandom_range(0, 255));
        f.byte1        = 8'($urandom_range(0, 255));
        f.byte2        = 8'($urandom_range(0, 255));
        f.byte3        = 8'($urandom_range(0, 255));
        f.byte4        = 8'($urandom_range(0, 255));
        f.now_seconds  = $urandom;
      end
      1: begin
        do begin
          f.frame_length = 4'($urandom_range(0, 15));
        end while (f.frame_length == FRAME_LEN);
      end
      2: f.byte0 = cur_header ^ 8'($urandom_range(1, 255));
      default: f.byte4 = f.byte4 ^ (8'h01 << $urandom_range(0, 7));
    endcase
    return f;
  endfunction

  // Offers one frame after an optional gap and returns at the edge that takes it.
  task automatic send_frame(input in_item_t f);
    int unsigned gap;
    gap = send_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.frame_length <= f.frame_length;
    in_if.byte0        <= f.byte0;
    in_if.byte1        <= f.byte1;
    in_if.byte2        <= f.byte2;
    in_if.byte3        <= f.byte3;
    in_if.byte4        <= f.byte4;
    in_if.now_seconds  <= f.now_seconds;
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
  endtask

  task automatic send_reading(input logic [15:0] w, input logic [31:0] step);
    sim_seconds = sim_seconds + step;
    send_frame(build_frame(w, sim_seconds, 1'b0));
  endtask

  // Stops offering frames and waits until every result has come back.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (readings_seen != frames_sent) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle.
  task automatic configure(input logic [7:0] hdr, input logic [7:0] rep,
                           input logic [15:0] tmo);
    wait_drain();
    cur_header  = hdr;
    cur_repeats = rep;
    cur_timeout = tmo;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER_BYTE;
    cfg_wdata <= {8'h00, hdr};
    @(posedge clk);
    cfg_index <= CFG_STABLE_REPEATS;
    cfg_wdata <= {8'h00, rep};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_SECONDS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Rejections at reset settings, including check order and an oversized checksum.
  task automatic test_frame_checks();
    in_item_t f;
    send_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    f = build_frame(16'h0321, sim_seconds, 1'b0);
    f.frame_length = 4'd4;
    send_frame(f);
    f.frame_length = 4'd0;
    f.byte0        = ~HEADER_RESET;
    send_frame(f);
    f.frame_length = 4'd15;
    send_frame(f);
    f = build_frame(16'h0321, sim_seconds, 1'b0);
    f.byte0 = cur_header ^ 8'h80;
    f.byte4 = f.byte4 ^ 8'h01;
    send_frame(f);
    f = build_frame(16'h0321, sim_seconds, 1'b0);
    f.byte4 = f.byte4 ^ 8'h10;
    send_frame(f);
    send_frame(build_frame(16'hFFFF, sim_seconds, 1'b1));
    send_reading(16'hFFFF, 32'd1);
  endtask

  // Push at the configured count, and no push for a zero weight.
  task automatic test_stable_push();
    repeat (12) send_reading(16'h0BEE, 32'd1);
    configure(HEADER_RESET, 8'd2, TIMEOUT_RESET);
    repeat (3) send_reading(16'h0000, 32'd1);
  endtask

  // Timeout boundary, backward steps and the sign of the time difference.
  task automatic test_timeout();
    configure(HEADER_RESET, 8'd3, TIMEOUT_RESET);
    send_reading(16'h4321, 32'd1);
    send_reading(16'h4321, 32'd15);
    send_reading(16'h4321, 32'd16);
    send_reading(16'h4321, 32'd0 - 32'd5);
    send_reading(16'h4321, 32'h8000_0000);
    send_reading(16'h4321, 32'h7FFF_FFFF);
  endtask

  // Long run of one weight: push once at 255, then the count holds.
  task automatic test_count_saturation();
    logic [15:0] w;
    configure(8'hFF, 8'd255, 16'hFFFF);
    send_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    w = 16'($urandom_range(1, 65535));
    repeat (258) send_reading(w, $urandom_range(0, 2));
  endtask

  // The receiver holds off while frames keep coming, then the sender pauses.
  task automatic test_backpressure();
    configure(HEADER_RESET, 8'd4, 16'd20);
    send_idle_en  = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_len = 200;
    repeat (30) send_reading(pick_weight() & 16'h0003, $urandom_range(0, 2));
    wait_drain();
    repeat (6) send_reading(16'h0002, 32'd1);
  endtask

  // Mostly runs of one weight with random content, mixed with broken frames.
  task automatic run_phase(input logic [7:0] hdr, input logic [7:0] rep, input logic [15:0] tmo,
                           input int unsigned n_frames, input bit idle_in, input bit idle_out);
    int unsigned sent_here;
    int unsigned run_len;
    int unsigned k;
    logic [15:0] w;
    configure(hdr, rep, tmo);
    send_idle_en = idle_in;
    sink_idle_en = idle_out;
    sent_here = 0;
    while (sent_here < n_frames) begin
      if ($urandom_range(0, 99) < 80) begin
        w       = pick_weight();
        run_len = $urandom_range(1, cur_repeats + 3);
        for (k = 0; k < run_len && sent_here < n_frames; k++) begin
          if ($urandom_range(0, 99) < 4) send_frame(build_noise());
          else send_reading(w, pick_step());
          sent_here++;
        end
      end else begin
        send_frame(build_noise());
        sent_here++;
      end
    end
  endtask

  task automatic test_random_settings();
    run_phase(8'h00, 8'd1, 16'd0, 110, 1'b1, 1'b1);
    run_phase(8'hA5, 8'd2, 16'hFFFF, 110, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'd3, 16'($urandom_range(1, 30)), 110, 1'b1, 1'b0);
    run_phase(HEADER_RESET, 8'($urandom_range(4, 20)), TIMEOUT_RESET, 110, 1'b0, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 8'd0, 16'($urandom_range(0, 65535)), 60, 1'b1, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(5, 40)),
              16'($urandom_range(0, 100)), 110, 1'b1, 1'b1);
  endtask

  // Every accepted frame gets its expected result.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_readings.push_back(predict_reading('{
        frame_length: in_if.frame_length, byte0: in_if.byte0, byte1: in_if.byte1,
        byte2: in_if.byte2, byte3: in_if.byte3, byte4: in_if.byte4,
        now_seconds: in_if.now_seconds}));
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_reading
    reading_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        $error("unexpected result: status %0d weight %0d", out_if.status, out_if.weight_tenths);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.weight_tenths !== want.weight) begin
          $error("weight_tenths: expected %0d, actual %0d", want.weight, out_if.weight_tenths);
          fail_count++;
        end
        if (out_if.repeat_count !== want.count) begin
          $error("repeat_count: expected %0d, actual %0d", want.count, out_if.repeat_count);
          fail_count++;
        end
        if (out_if.stable_push !== want.push) begin
          $error("stable_push: expected %0d, actual %0d", want.push, out_if.stable_push);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when a test asks for one.
  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
        out_if.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // End the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_HEADER_BYTE;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.frame_length = '0;
    in_if.byte0        = '0;
    in_if.byte1        = '0;
    in_if.byte2        = '0;
    in_if.byte3        = '0;
    in_if.byte4        = '0;
    in_if.now_seconds  = '0;
    send_idle_en       = 1'b0;
    sink_idle_en       = 1'b0;
    sink_hold_len      = 0;
    frames_sent        = 0;
    readings_seen      = 0;
    fail_count         = 0;
    cur_header         = HEADER_RESET;
    cur_repeats        = REPEATS_RESET;
    cur_timeout        = TIMEOUT_RESET;
    hist_weight        = '0;
    hist_known         = 1'b0;
    hist_count         = '0;
    hist_time          = '0;
    // Start just below the wrap so the seconds counter rolls over early.
    sim_seconds        = 32'hFFFF_FFF8;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_frame_checks();
    test_stable_push();
    test_timeout();
    test_backpressure();
    test_count_saturation();
    test_random_settings();

    wait_drain();
    repeat (8) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d expected results never arrived", expected_readings.size());
      fail_count++;
    end
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sfsr_pkg.sv
design/sfsr_in_if.sv
design/sfsr_out_if.sv
design/scale_frame_stable_reading.sv
bench/scale_frame_stable_reading_tb.sv
